>>> rtl/assert_macros.svh
// Assertion macros for the RTL file that checks its own behaviour.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every rising edge of i_clk outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// A condition that must never be true at a rising edge of i_clk outside reset.
`define ASSERT_NEVER(label, expr, msg) \
    `ASSERT_CLK(label, !(expr), msg)

`endif

>>> rtl/gps_pkg.sv
package gps_pkg;

    localparam int WORD_W    = 16;
    localparam int COEFF_W   = 6;
    localparam int IDX_W     = 10;
    localparam int NORM_W    = 19;
    localparam int LD_W      = 4;
    localparam int STATUS_W  = 2;

    localparam int KMAX_512  = 17;
    localparam int KMAX_1024 = 12;
    localparam int CDT512_N  = 2 * KMAX_512;
    localparam int CDT1024_N = 2 * KMAX_1024;

    localparam logic [LD_W-1:0] LD_512  = 4'd9;
    localparam logic [LD_W-1:0] LD_1024 = 4'd10;

    localparam logic [NORM_W-1:0] NORM_BOUND_RST = 19'd16823;

    localparam logic [WORD_W-1:0] CDT_512 [CDT512_N] = '{
        16'd1,     16'd4,     16'd11,    16'd28,    16'd65,    16'd146,
        16'd308,   16'd615,   16'd1164,  16'd2083,  16'd3535,  16'd5692,
        16'd8706,  16'd12669, 16'd17574, 16'd23285, 16'd29542, 16'd35993,
        16'd42250, 16'd47961, 16'd52866, 16'd56829, 16'd59843, 16'd62000,
        16'd63452, 16'd64371, 16'd64920, 16'd65227, 16'd65389, 16'd65470,
        16'd65507, 16'd65524, 16'd65531, 16'd65534
    };

    localparam logic [WORD_W-1:0] CDT_1024 [CDT1024_N] = '{
        16'd2,     16'd8,     16'd28,    16'd94,    16'd280,   16'd742,
        16'd1761,  16'd3753,  16'd7197,  16'd12472, 16'd19623, 16'd28206,
        16'd37329, 16'd45912, 16'd53063, 16'd58338, 16'd61782, 16'd63774,
        16'd64793, 16'd65255, 16'd65441, 16'd65507, 16'd65527, 16'd65533
    };

    typedef enum logic [0:0] {
        CFG_LOG_DEGREE = 1'b0,
        CFG_NORM_BOUND = 1'b1
    } t_cfg_reg;

    typedef enum logic [STATUS_W-1:0] {
        PAIR_NONE = 2'd0,
        PAIR_PASS = 2'd1,
        PAIR_FAIL = 2'd2
    } t_pair_status;

    typedef struct packed {
        logic signed [COEFF_W-1:0] coeff;
        logic                      poly_is_g;
        logic [IDX_W-1:0]          coeff_index;
        logic                      last_of_poly;
        logic                      poly_accepted;
        t_pair_status              pair_status;
    } t_result;

endpackage

>>> rtl/gps_cdt.sv
module gps_cdt
    import gps_pkg::*;
#(
    parameter int MAX_TAIL = 17
) (
    input  logic [WORD_W-1:0]         i_word,
    input  logic                      i_is_1024,
    output logic signed [COEFF_W-1:0] o_coeff
);

    localparam int CNT_W = $clog2(CDT512_N + 1);
    localparam logic signed [COEFF_W:0] TAIL_P = (COEFF_W + 1)'(MAX_TAIL);
    localparam logic signed [COEFF_W:0] TAIL_N = -TAIL_P;

    logic [CDT512_N-1:0]         below_512;
    logic [CDT1024_N-1:0]        below_1024;
    logic [CNT_W-1:0]            cnt;
    logic signed [COEFF_W:0]     kmax;
    logic signed [COEFF_W:0]     diff;
    logic signed [COEFF_W:0]     sat;

    always_comb begin
        for (int k = 0; k < CDT512_N; k++) begin
            below_512[k] = CDT_512[k] < i_word;
        end
        for (int k = 0; k < CDT1024_N; k++) begin
            below_1024[k] = CDT_1024[k] < i_word;
        end
    end

    always_comb begin
        if (i_is_1024) begin
            cnt  = CNT_W'($countones(below_1024));
            kmax = (COEFF_W + 1)'(KMAX_1024);
        end else begin
            cnt  = CNT_W'($countones(below_512));
            kmax = (COEFF_W + 1)'(KMAX_512);
        end
        diff = $signed((COEFF_W + 1)'(cnt)) - kmax;
        if (diff > TAIL_P) begin
            sat = TAIL_P;
        end else if (diff < TAIL_N) begin
            sat = TAIL_N;
        end else begin
            sat = diff;
        end
    end

    assign o_coeff = sat[COEFF_W-1:0];

endmodule

>>> rtl/gaussian_poly_sampler_norm_check.sv
// Gaussian coefficient sampler for f and g polynomials. Every accepted 16-bit random word yields
// exactly one output word via the input and output registers, and one word can be accepted
// in every cycle while the output side is ready. The input register feeds a parallel bank
// of comparators against the cumulative table, whose count, squared coefficient and running
// parity and norm are settled in the same cycle into the output register; that one stage sets
// the rate of one word per cycle. A polynomial of even parity is dropped and sampled again; after
// an accepted g the output word carries the verdict of the pair norm against norm_bound. The
// user must write configuration only while no word is in flight; the block does not check it.
`include "assert_macros.svh"

module gaussian_poly_sampler_norm_check
    import gps_pkg::*;
#(
    parameter int MAX_LOG_DEGREE = 10,
    parameter int MAX_TAIL       = 17
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [0:0]        i_cfg_addr,
    input  logic [NORM_W-1:0] i_cfg_wdata,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // [15:0] random_word
    input  logic [15:0]       s_axis_tdata,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // [5:0] coeff, [15:6] coeff_index, [16] poly_accepted, [18:17] pair_status, [23:19] zero
    output logic [23:0]       m_axis_tdata,
    // [0] poly_is_g
    output logic              m_axis_tuser,
    output logic              m_axis_tlast
);

    localparam logic [LD_W-1:0] LD_MAX = LD_W'(MAX_LOG_DEGREE);

    logic [LD_W-1:0]   r_log_degree;
    logic [NORM_W-1:0] r_norm_bound;
    logic              r_in_valid;
    logic [WORD_W-1:0] r_word;
    logic              r_out_valid;
    t_result           r_out;
    t_result           n_out;
    logic              r_sampling_g;
    logic              n_sampling_g;
    logic [IDX_W-1:0]  r_index;
    logic [IDX_W-1:0]  n_index;
    logic              r_parity;
    logic              n_parity;
    logic [NORM_W-1:0] r_norm;
    logic [NORM_W-1:0] n_norm;
    logic [NORM_W-1:0] r_f_norm;
    logic [NORM_W-1:0] n_f_norm;

    logic                      advance;
    logic [LD_W-1:0]           ld_lo;
    logic [LD_W-1:0]           ld_eff;
    logic                      is_1024;
    logic [IDX_W-1:0]          last_idx;
    logic signed [COEFF_W-1:0] coeff;
    logic signed [2*COEFF_W-1:0] prod;
    logic [NORM_W-1:0]         new_norm;
    logic                      new_par;
    logic                      last;
    logic [NORM_W:0]           pair_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_log_degree <= LD_512;
            r_norm_bound <= NORM_BOUND_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_addr))
                CFG_LOG_DEGREE: r_log_degree <= i_cfg_wdata[LD_W-1:0];
                CFG_NORM_BOUND: r_norm_bound <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_word <= s_axis_tdata;
        end
    end

    always_comb begin
        ld_lo    = (r_log_degree < LD_512) ? LD_512 : r_log_degree;
        ld_eff   = (ld_lo > LD_MAX) ? LD_MAX : ld_lo;
        is_1024  = ld_eff == LD_1024;
        last_idx = is_1024 ? {IDX_W{1'b1}} : {1'b0, {(IDX_W - 1){1'b1}}};
    end

    gps_cdt #(
        .MAX_TAIL(MAX_TAIL)
    ) u_cdt (
        .i_word   (r_word),
        .i_is_1024(is_1024),
        .o_coeff  (coeff)
    );

    always_comb begin
        prod     = coeff * coeff;
        new_norm = r_norm + NORM_W'(prod[8:0]);
        new_par  = r_parity ^ coeff[0];
        last     = r_index >= last_idx;
        pair_sum = {1'b0, r_f_norm} + {1'b0, new_norm};

        n_out.coeff         = coeff;
        n_out.poly_is_g     = r_sampling_g;
        n_out.coeff_index   = r_index;
        n_out.last_of_poly  = last;
        n_out.poly_accepted = last && new_par;
        n_out.pair_status   = PAIR_NONE;

        n_sampling_g = r_sampling_g;
        n_f_norm     = r_f_norm;
        if (last) begin
            n_index  = '0;
            n_parity = 1'b0;
            n_norm   = '0;
            if (new_par) begin
                if (r_sampling_g) begin
                    n_out.pair_status = (pair_sum < {1'b0, r_norm_bound}) ? PAIR_PASS
                                                                          : PAIR_FAIL;
                    n_sampling_g = 1'b0;
                    n_f_norm     = '0;
                end else begin
                    n_sampling_g = 1'b1;
                    n_f_norm     = new_norm;
                end
            end
        end else begin
            n_index  = r_index + 1'b1;
            n_parity = new_par;
            n_norm   = new_norm;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sampling_g <= 1'b0;
            r_index      <= '0;
            r_parity     <= 1'b0;
            r_norm       <= '0;
            r_f_norm     <= '0;
        end else if (advance) begin
            r_sampling_g <= n_sampling_g;
            r_index      <= n_index;
            r_parity     <= n_parity;
            r_norm       <= n_norm;
            r_f_norm     <= n_f_norm;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'b0, r_out.pair_status, r_out.poly_accepted,
                            r_out.coeff_index, r_out.coeff};
    assign m_axis_tuser  = r_out.poly_is_g;
    assign m_axis_tlast  = r_out.last_of_poly;

    `ASSERT_CLK(a_status_on_accepted_g,
        (m_axis_tvalid && r_out.pair_status != PAIR_NONE) |->
            (r_out.last_of_poly && r_out.poly_accepted && r_out.poly_is_g),
        "pair verdict outside the final word of an accepted g")

    `ASSERT_NEVER(a_accept_not_last,
        m_axis_tvalid && r_out.poly_accepted && !r_out.last_of_poly,
        "polynomial accepted before its final word")

    `ASSERT_CLK(a_pair_restarts_f,
        (advance && last && new_par && r_sampling_g) |=> (!r_sampling_g && r_f_norm == '0),
        "sampling did not restart at f after a pair verdict")

    `ASSERT_NEVER(a_index_restart,
        advance && last && n_index != '0,
        "coefficient index not cleared at the end of a polynomial")

endmodule

>>> verif/gaussian_poly_sampler_norm_check_test.sv
`timescale 1ns / 1ps

module gaussian_poly_sampler_norm_check_test;
    import gps_pkg::*;

    localparam int STALL_LIMIT = 2000;

    localparam logic [15:0] TAB_512 [34] = '{
        16'd1,     16'd4,     16'd11,    16'd28,    16'd65,    16'd146,
        16'd308,   16'd615,   16'd1164,  16'd2083,  16'd3535,  16'd5692,
        16'd8706,  16'd12669, 16'd17574, 16'd23285, 16'd29542, 16'd35993,
        16'd42250, 16'd47961, 16'd52866, 16'd56829, 16'd59843, 16'd62000,
        16'd63452, 16'd64371, 16'd64920, 16'd65227, 16'd65389, 16'd65470,
        16'd65507, 16'd65524, 16'd65531, 16'd65534
    };

    localparam logic [15:0] TAB_1024 [24] = '{
        16'd2,     16'd8,     16'd28,    16'd94,    16'd280,   16'd742,
        16'd1761,  16'd3753,  16'd7197,  16'd12472, 16'd19623, 16'd28206,
        16'd37329, 16'd45912, 16'd53063, 16'd58338, 16'd61782, 16'd63774,
        16'd64793, 16'd65255, 16'd65441, 16'd65507, 16'd65527, 16'd65533
    };

    typedef enum int {
        WORDS_UNIFORM,
        WORDS_CENTRE,
        WORDS_TAILS
    } t_word_mix;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [0:0]        i_cfg_addr;
    logic [NORM_W-1:0] i_cfg_wdata;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    // [15:0] random_word
    logic [15:0]       s_axis_tdata;
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    // [5:0] coeff, [15:6] coeff_index, [16] poly_accepted, [18:17] pair_status, [23:19] zero
    logic [23:0]       m_axis_tdata;
    // [0] poly_is_g
    logic              m_axis_tuser;
    logic              m_axis_tlast;

    logic [LD_W-1:0]   cfg_log_degree;
    logic [NORM_W-1:0] cfg_norm_bound;
    logic              on_g;
    logic [IDX_W-1:0]  coeff_pos;
    logic              parity;
    logic [NORM_W-1:0] poly_norm;
    logic [NORM_W-1:0] f_norm;

    t_result expected_words[$];
    int      n_mismatch;
    int      idle_cycles;
    bit      calm;

    gaussian_poly_sampler_norm_check dut (.*);

    always #4 i_clk = ~i_clk;

    function automatic int effective_log_degree();
        int ld;
        ld = cfg_log_degree;
        if (ld < 9) ld = 9;
        if (ld > 10) ld = 10;
        return ld;
    endfunction

    function automatic int coeff_of(logic [15:0] w);
        int cnt;
        cnt = 0;
        if (effective_log_degree() == 10) begin
            foreach (TAB_1024[k]) if (TAB_1024[k] < w) cnt++;
            return cnt - KMAX_1024;
        end
        foreach (TAB_512[k]) if (TAB_512[k] < w) cnt++;
        return cnt - KMAX_512;
    endfunction

    function automatic bit next_is_last();
        return coeff_pos >= IDX_W'((1 << effective_log_degree()) - 1);
    endfunction

    function automatic t_result sample_word(logic [15:0] w);
        t_result           r;
        int                c;
        logic              new_par;
        logic [NORM_W-1:0] new_norm;
        logic [NORM_W:0]   pair_sum;
        c = coeff_of(w);
        new_par = parity ^ c[0];
        new_norm = poly_norm + NORM_W'(c * c);
        r.coeff = COEFF_W'(c);
        r.poly_is_g = on_g;
        r.coeff_index = coeff_pos;
        r.last_of_poly = next_is_last();
        r.poly_accepted = 1'b0;
        r.pair_status = PAIR_NONE;
        if (r.last_of_poly) begin
            r.poly_accepted = new_par;
            if (new_par) begin
                if (on_g) begin
                    pair_sum = {1'b0, f_norm} + new_norm;
                    if (pair_sum < cfg_norm_bound) begin
                        r.pair_status = PAIR_PASS;
                    end else begin
                        r.pair_status = PAIR_FAIL;
                    end
                    on_g = 1'b0;
                    f_norm = '0;
                end else begin
                    f_norm = new_norm;
                    on_g = 1'b1;
                end
            end
            coeff_pos = '0;
            parity = 1'b0;
            poly_norm = '0;
        end else begin
            coeff_pos = coeff_pos + 1'b1;
            parity = new_par;
            poly_norm = new_norm;
        end
        return r;
    endfunction

    function automatic logic [15:0] pick_word(t_word_mix mix);
        case (mix)
            WORDS_CENTRE: begin
                // Words in this band give a zero coefficient with either table.
                if ($urandom_range(9) != 0) return 16'($urandom_range(35993, 29543));
            end
            WORDS_TAILS: begin
                if ($urandom_range(1) != 0) return 16'($urandom_range(65535, 65500));
                return 16'($urandom_range(40, 0));
            end
            default: ;
        endcase
        return 16'($urandom_range(65535, 0));
    endfunction

    task automatic send_word(input logic [15:0] w);
        if (!calm && $urandom_range(99) < 24) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= w;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        expected_words.push_back(sample_word(w));
        @(negedge i_clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (expected_words.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_register(input t_cfg_reg sel, input logic [NORM_W-1:0] value);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= sel;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (sel)
            CFG_LOG_DEGREE: cfg_log_degree = value[LD_W-1:0];
            CFG_NORM_BOUND: cfg_norm_bound = value;
            default: ;
        endcase
    endtask

    task automatic run_words(input int n, input t_word_mix mix);
        repeat (n) send_word(pick_word(mix));
    endtask

    // The closing word is chosen so that the polynomial ends with the wanted parity.
    task automatic finish_poly(input bit want_odd, input t_word_mix mix);
        logic [15:0] w;
        int          c;
        while (!next_is_last()) send_word(pick_word(mix));
        forever begin
            w = pick_word(mix);
            c = coeff_of(w);
            if ((parity ^ c[0]) == want_odd) break;
        end
        send_word(w);
    endtask

    task automatic test_table_edges();
        logic [15:0] probes_512 [12] = '{
            16'd0, 16'd1, 16'd2, 16'd4, 16'd5, 16'd29542, 16'd29543,
            16'd35993, 16'd35994, 16'd65533, 16'd65534, 16'd65535
        };
        logic [15:0] probes_1024 [9] = '{
            16'd0, 16'd2, 16'd3, 16'd28206, 16'd28207, 16'd65532,
            16'd65533, 16'd65534, 16'd65535
        };
        foreach (probes_512[k]) send_word(probes_512[k]);
        write_register(CFG_LOG_DEGREE, NORM_W'(LD_1024));
        foreach (probes_1024[k]) send_word(probes_1024[k]);
        write_register(CFG_LOG_DEGREE, NORM_W'(15));
        send_word(16'd65535);
        send_word(16'd0);
        write_register(CFG_LOG_DEGREE, NORM_W'(0));
        send_word(16'd65535);
        send_word(16'd0);
        write_register(CFG_LOG_DEGREE, NORM_W'(LD_512));
    endtask

    task automatic test_degree_switch();
        write_register(CFG_LOG_DEGREE, NORM_W'(LD_1024));
        run_words(505, WORDS_UNIFORM);
        write_register(CFG_LOG_DEGREE, NORM_W'(LD_512));
        finish_poly(1'b1, WORDS_UNIFORM);
    endtask

    task automatic test_rejected_g();
        run_words(200, WORDS_TAILS);
        write_register(CFG_NORM_BOUND, '0);
        finish_poly(1'b0, WORDS_TAILS);
    endtask

    task automatic test_pair_fail();
        calm = 1'b1;
        finish_poly(1'b1, WORDS_UNIFORM);
        calm = 1'b0;
    endtask

    task automatic flag(input string what, input logic [23:0] want, input logic [23:0] got);
        n_mismatch++;
        if (n_mismatch <= 10) begin
            $display("%0t: %s expected %0h got %0h", $time, what, want, got);
        end
    endtask

    task automatic check_word();
        t_result want;
        if (expected_words.size() == 0) begin
            flag("unexpected word", '0, m_axis_tdata);
            return;
        end
        want = expected_words.pop_front();
        if (want.coeff !== m_axis_tdata[5:0])
            flag("coeff", {18'd0, want.coeff}, {18'd0, m_axis_tdata[5:0]});
        if (want.coeff_index !== m_axis_tdata[15:6])
            flag("coeff_index", {14'd0, want.coeff_index}, {14'd0, m_axis_tdata[15:6]});
        if (want.poly_accepted !== m_axis_tdata[16])
            flag("poly_accepted", {23'd0, want.poly_accepted}, {23'd0, m_axis_tdata[16]});
        if (want.pair_status !== m_axis_tdata[18:17])
            flag("pair_status", {22'd0, want.pair_status}, {22'd0, m_axis_tdata[18:17]});
        if (m_axis_tdata[23:19] !== '0)
            flag("padding", '0, {19'd0, m_axis_tdata[23:19]});
        if (want.poly_is_g !== m_axis_tuser)
            flag("poly_is_g", {23'd0, want.poly_is_g}, {23'd0, m_axis_tuser});
        if (want.last_of_poly !== m_axis_tlast)
            flag("last_of_poly", {23'd0, want.last_of_poly}, {23'd0, m_axis_tlast});
    endtask

    always @(negedge i_clk) begin
        m_axis_tready <= calm || ($urandom_range(99) >= 24);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (m_axis_tvalid && m_axis_tready) check_word();
        end
    end

    always @(posedge i_clk) begin
        if (idle_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_addr     = '0;
        i_cfg_wdata    = '0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        m_axis_tready  = 1'b0;
        cfg_log_degree = LD_512;
        cfg_norm_bound = NORM_BOUND_RST;
        on_g           = 1'b0;
        coeff_pos      = '0;
        parity         = 1'b0;
        poly_norm      = '0;
        f_norm         = '0;
        n_mismatch     = 0;
        idle_cycles    = 0;
        calm           = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_table_edges();
        test_degree_switch();
        test_rejected_g();
        test_pair_fail();
        drain();
        repeat (8) @(posedge i_clk);
        if (n_mismatch == 0 && expected_words.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl
rtl/gps_pkg.sv
rtl/gps_cdt.sv
rtl/gaussian_poly_sampler_norm_check.sv
verif/gaussian_poly_sampler_norm_check_test.sv
